>>> design/btm2d_pkg.sv
// Shared types and constants for the binary 2D template matcher.
// Holds the microcode format, condition codes, step names and the control ROM.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package btm2d_pkg;

    // request function codes
    localparam logic [1:0] FUNC_IMAGE    = 2'd0;
    localparam logic [1:0] FUNC_TEMPLATE = 2'd1;
    localparam logic [1:0] FUNC_SEARCH   = 2'd2;

    // configuration register indexes
    localparam logic CFG_IMAGE_SIZE    = 1'b0;
    localparam logic CFG_TEMPLATE_SIZE = 1'b1;

    localparam int CFG_W = 7;
    localparam int PC_W  = 4;

    // program steps
    localparam logic [PC_W-1:0] S_IDLE     = 4'd0;
    localparam logic [PC_W-1:0] S_INIT     = 4'd1;
    localparam logic [PC_W-1:0] S_READ     = 4'd2;
    localparam logic [PC_W-1:0] S_CMP      = 4'd3;
    localparam logic [PC_W-1:0] S_NEXT_ROW = 4'd4;
    localparam logic [PC_W-1:0] S_HIT      = 4'd5;
    localparam logic [PC_W-1:0] S_NEXT_COL = 4'd6;
    localparam logic [PC_W-1:0] S_NEXT_OFF = 4'd7;
    localparam logic [PC_W-1:0] S_DONE     = 4'd8;
    localparam logic [PC_W-1:0] S_END      = 4'd9;

    // jump conditions: jump to target when true, else step to pc + 1
    localparam logic [2:0] C_ALWAYS    = 3'd0;
    localparam logic [2:0] C_NOT_START = 3'd1;
    localparam logic [2:0] C_NO_FIT    = 3'd2;
    localparam logic [2:0] C_MISMATCH  = 3'd3;
    localparam logic [2:0] C_K_MORE    = 3'd4;
    localparam logic [2:0] C_J_MORE    = 3'd5;
    localparam logic [2:0] C_I_MORE    = 3'd6;
    localparam logic [2:0] C_OUT_BUSY  = 3'd7;

    typedef struct packed {
        logic idle;
        logic init;
        logic rd;
        logic inc_k;
        logic next_j;
        logic next_i;
        logic set_found;
        logic emit;
    } dp_ctrl_t;

    typedef struct packed {
        logic start;
        logic no_fit;
        logic mismatch;
        logic k_more;
        logic j_more;
        logic i_more;
        logic out_busy;
    } dp_stat_t;

    typedef struct packed {
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
        dp_ctrl_t        ctrl;
    } ucode_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '0;
        unique case (pc)
            S_IDLE: begin
                w.ctrl.idle = 1'b1;
                w.cond      = C_NOT_START;
                w.target    = S_IDLE;
            end
            S_INIT: begin
                w.ctrl.init = 1'b1;
                w.cond      = C_NO_FIT;
                w.target    = S_DONE;
            end
            S_READ: begin
                w.ctrl.rd = 1'b1;
                w.cond    = C_ALWAYS;
                w.target  = S_CMP;
            end
            S_CMP: begin
                w.cond   = C_MISMATCH;
                w.target = S_NEXT_COL;
            end
            S_NEXT_ROW: begin
                w.ctrl.inc_k = 1'b1;
                w.cond       = C_K_MORE;
                w.target     = S_READ;
            end
            S_HIT: begin
                w.ctrl.set_found = 1'b1;
                w.cond           = C_ALWAYS;
                w.target         = S_DONE;
            end
            S_NEXT_COL: begin
                w.ctrl.next_j = 1'b1;
                w.cond        = C_J_MORE;
                w.target      = S_READ;
            end
            S_NEXT_OFF: begin
                w.ctrl.next_i = 1'b1;
                w.cond        = C_I_MORE;
                w.target      = S_READ;
            end
            S_DONE: begin
                w.ctrl.emit = 1'b1;
                w.cond      = C_OUT_BUSY;
                w.target    = S_DONE;
            end
            S_END: begin
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> design/btm2d_store.sv
// Square binary pixel store: single-pixel writes, one full row read per cycle.
// Read data is registered. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module btm2d_store #(
    parameter int MAX_SIDE = 64
) (
    input  wire logic                        clk,
    input  wire logic                        we,
    input  wire logic [$clog2(MAX_SIDE)-1:0] wr_row,
    input  wire logic [$clog2(MAX_SIDE)-1:0] wr_col,
    input  wire logic                        wr_bit,
    input  wire logic                        rd_en,
    input  wire logic [$clog2(MAX_SIDE)-1:0] rd_row,
    output logic      [MAX_SIDE-1:0]         rd_data
);

    logic [MAX_SIDE-1:0] mem [MAX_SIDE];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_row][wr_col] <= wr_bit;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_row];
        end
    end

endmodule

`default_nettype wire

>>> design/btm2d_dpath.sv
// Datapath of the template matcher: offset and row counters, the two pixel
// stores, the masked row compare and the result register. Uses btm2d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btm2d_dpath #(
    parameter int MAX_SIDE = 64
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire btm2d_pkg::dp_ctrl_t              ctrl,
    output btm2d_pkg::dp_stat_t                   stat,
    input  wire logic                             start,
    input  wire logic [btm2d_pkg::CFG_W-1:0]      image_size,
    input  wire logic [btm2d_pkg::CFG_W-1:0]      template_size,
    input  wire logic                             wr_img,
    input  wire logic                             wr_tpl,
    input  wire logic [$clog2(MAX_SIDE)-1:0]      wr_row,
    input  wire logic [$clog2(MAX_SIDE)-1:0]      wr_col,
    input  wire logic                             wr_bit,
    input  wire logic                             out_stall,
    output logic                                  out_valid,
    output logic                                  found
);

    localparam int AW = $clog2(MAX_SIDE);
    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam logic [MAX_SIDE-1:0] ONES = '1;

    logic [AW-1:0]       i_reg, j_reg, k_reg;
    logic [AW-1:0]       i_next, j_next, k_next;
    logic [AW-1:0]       t_last_reg, span_last_reg;
    logic [MAX_SIDE-1:0] mask_reg;
    logic                found_reg, found_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_found_reg;
    logic [SW-1:0]       n_side, t_side;
    logic [MAX_SIDE-1:0] img_row, tpl_row, img_shift;

    // zero acts as one, anything above the store side acts as the store side
    always_comb
    begin
        if (image_size == '0)
            n_side = SW'(1);
        else if (32'(image_size) > MAX_SIDE)
            n_side = SW'(MAX_SIDE);
        else
            n_side = SW'(image_size);

        if (template_size == '0)
            t_side = SW'(1);
        else if (32'(template_size) > MAX_SIDE)
            t_side = SW'(MAX_SIDE);
        else
            t_side = SW'(template_size);
    end

    btm2d_store #(.MAX_SIDE(MAX_SIDE)) u_img (
        .clk     (clk),
        .we      (wr_img),
        .wr_row  (wr_row),
        .wr_col  (wr_col),
        .wr_bit  (wr_bit),
        .rd_en   (ctrl.rd),
        .rd_row  (AW'(i_reg + k_reg)),
        .rd_data (img_row)
    );

    btm2d_store #(.MAX_SIDE(MAX_SIDE)) u_tpl (
        .clk     (clk),
        .we      (wr_tpl),
        .wr_row  (wr_row),
        .wr_col  (wr_col),
        .wr_bit  (wr_bit),
        .rd_en   (ctrl.rd),
        .rd_row  (k_reg),
        .rd_data (tpl_row)
    );

    // image row aligned to column offset j, only the template width compared
    assign img_shift = img_row >> j_reg;

    always_comb
    begin
        stat.start    = start;
        stat.no_fit   = t_side > n_side;
        stat.mismatch = |((img_shift ^ tpl_row) & mask_reg);
        stat.k_more   = k_reg != t_last_reg;
        stat.j_more   = j_reg != span_last_reg;
        stat.i_more   = i_reg != span_last_reg;
        stat.out_busy = out_valid_reg && out_stall;
    end

    always_comb
    begin
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        found_next = found_reg;
        if (ctrl.init)
        begin
            i_next     = '0;
            j_next     = '0;
            k_next     = '0;
            found_next = 1'b0;
        end
        if (ctrl.inc_k)
            k_next = AW'(k_reg + 1'b1);
        if (ctrl.next_j)
        begin
            k_next = '0;
            j_next = AW'(j_reg + 1'b1);
        end
        if (ctrl.next_i)
        begin
            j_next = '0;
            i_next = AW'(i_reg + 1'b1);
        end
        if (ctrl.set_found)
            found_next = 1'b1;

        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (ctrl.emit && !stat.out_busy)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.init)
        begin
            t_last_reg    <= AW'(t_side - 1'b1);
            span_last_reg <= AW'(n_side - t_side);
            mask_reg      <= ~(ONES << t_side);
        end
        if (ctrl.emit && !stat.out_busy)
            out_found_reg <= found_reg;
    end

    assign out_valid = out_valid_reg;
    assign found     = out_found_reg;

endmodule

`default_nettype wire

>>> design/btm2d_seq.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jump.
// Uses btm2d_pkg for the word format and the program.
`timescale 1ns / 1ps
`default_nettype none

module btm2d_seq (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire btm2d_pkg::dp_stat_t          stat,
    output btm2d_pkg::dp_ctrl_t               ctrl,
    output logic [btm2d_pkg::PC_W-1:0]        pc
);

    logic [btm2d_pkg::PC_W-1:0] pc_reg, pc_next;
    btm2d_pkg::ucode_t          word;
    logic                       take;

    assign word = btm2d_pkg::ucode_rom(pc_reg);

    always_comb
    begin
        unique case (word.cond)
            btm2d_pkg::C_ALWAYS:    take = 1'b1;
            btm2d_pkg::C_NOT_START: take = !stat.start;
            btm2d_pkg::C_NO_FIT:    take = stat.no_fit;
            btm2d_pkg::C_MISMATCH:  take = stat.mismatch;
            btm2d_pkg::C_K_MORE:    take = stat.k_more;
            btm2d_pkg::C_J_MORE:    take = stat.j_more;
            btm2d_pkg::C_I_MORE:    take = stat.i_more;
            btm2d_pkg::C_OUT_BUSY:  take = stat.out_busy;
            default:                take = 1'b1;
        endcase
        pc_next = take ? word.target : btm2d_pkg::PC_W'(pc_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= btm2d_pkg::S_IDLE;
        else
            pc_reg <= pc_next;
    end

    assign ctrl = word.ctrl;
    assign pc   = pc_reg;

endmodule

`default_nettype wire

>>> design/binary_template_match_2d_unit.sv
// Top level of the binary 2D template matcher: configuration registers,
// request decode and the sequencer/datapath pair. Uses btm2d_pkg, btm2d_seq,
// btm2d_dpath.
//
//   channel   handshake              payload
//   --------  ---------------------  ------------------------------
//   request   in_valid / in_stall    func, row, col, pixel
//   result    out_valid / out_stall  found
//   config    cfg_we                 cfg_idx, cfg_wdata
//
// Each pixel write is a single request. A search with image side n, template side
// t and s = n-t+1 tries up to s^2 offsets, reading one row of each store per
// compare step; t > n finishes with no compare and reports not found.
// Requests stall while a search runs; a pending result does not block writes.
// Reset clears the sizes to 1 and the control state; pixel stores are not
// cleared. out_stall holds a search in its final step until the slot frees.
`timescale 1ns / 1ps
`default_nettype none

module binary_template_match_2d_unit #(
    parameter int MAX_SIDE = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_idx,
    input  wire logic [btm2d_pkg::CFG_W-1:0]   cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    func,
    input  wire logic [5:0]                    row,
    input  wire logic [5:0]                    col,
    input  wire logic                          pixel,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               found
);

    localparam int AW = $clog2(MAX_SIDE);

    logic [btm2d_pkg::CFG_W-1:0] image_size_reg, template_size_reg;
    logic [btm2d_pkg::CFG_W-1:0] image_size_next, template_size_next;
    btm2d_pkg::dp_ctrl_t         ctrl;
    btm2d_pkg::dp_stat_t         stat;
    logic [btm2d_pkg::PC_W-1:0]  seq_pc;
    logic                        in_take, in_range, start, wr_img, wr_tpl;

    always_comb
    begin
        image_size_next    = image_size_reg;
        template_size_next = template_size_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx)
                btm2d_pkg::CFG_IMAGE_SIZE:    image_size_next    = cfg_wdata;
                btm2d_pkg::CFG_TEMPLATE_SIZE: template_size_next = cfg_wdata;
                default:                      image_size_next    = image_size_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg    <= btm2d_pkg::CFG_W'(1);
            template_size_reg <= btm2d_pkg::CFG_W'(1);
        end
        else
        begin
            image_size_reg    <= image_size_next;
            template_size_reg <= template_size_next;
        end
    end

    assign in_stall = !ctrl.idle;
    assign in_take  = in_valid && !in_stall;
    assign in_range = (32'(row) < MAX_SIDE) && (32'(col) < MAX_SIDE);
    assign start    = in_take && (func == btm2d_pkg::FUNC_SEARCH);
    assign wr_img   = in_take && in_range && (func == btm2d_pkg::FUNC_IMAGE);
    assign wr_tpl   = in_take && in_range && (func == btm2d_pkg::FUNC_TEMPLATE);

    btm2d_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl),
        .pc    (seq_pc)
    );

    btm2d_dpath #(.MAX_SIDE(MAX_SIDE)) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .start         (start),
        .image_size    (image_size_reg),
        .template_size (template_size_reg),
        .wr_img        (wr_img),
        .wr_tpl        (wr_tpl),
        .wr_row        (AW'(row)),
        .wr_col        (AW'(col)),
        .wr_bit        (pixel),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .found         (found)
    );

    // a search request makes the block busy on the next cycle
    a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && func == btm2d_pkg::FUNC_SEARCH) |=> in_stall)
        else $error("search accepted but sequencer did not leave idle");

    // a new result only comes out of a running search
    a_result_from_search: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result raised without a search in progress");

    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
        seq_pc <= btm2d_pkg::S_END)
        else $error("step counter left the program");

endmodule

`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for binary_template_match_2d_unit.
// Drives pixel writes and searches, predicts each found flag, checks results in order.
// Depends on btm2d_pkg and the design sources.
`timescale 1ns / 1ps

module testbench;

    localparam int SIDE = 64;
    localparam int FRAME_SIDE = 16;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic                        cfg_idx = btm2d_pkg::CFG_IMAGE_SIZE;
    logic [btm2d_pkg::CFG_W-1:0] cfg_wdata = '0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [1:0]                  func = btm2d_pkg::FUNC_IMAGE;
    logic [5:0]                  row = '0;
    logic [5:0]                  col = '0;
    logic                        pixel = 1'b0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic                        found;

    // predictor state: pixel stores, which pixels were written, raw size registers
    bit [SIDE-1:0]               image_px [SIDE];
    bit [SIDE-1:0]               templ_px [SIDE];
    bit [SIDE-1:0]               image_wr [SIDE];
    bit [SIDE-1:0]               templ_wr [SIDE];
    logic [btm2d_pkg::CFG_W-1:0] image_side_reg = 7'd1;
    logic [btm2d_pkg::CFG_W-1:0] templ_side_reg = 7'd1;

    bit                pending_found [$];
    int unsigned       mismatch_count = 0;
    int unsigned       pixel_items = 0;
    int                gap_pct = 0;
    int                stall_pct = 0;

    binary_template_match_2d_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .row       (row),
        .col       (col),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .found     (found)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // outputs settle by mid-cycle; a result seen here is taken at the next edge
    always @(negedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (pending_found.size() == 0)
            begin
                $error("found: unexpected result %0b with no search pending", found);
                mismatch_count++;
            end
            else
            begin
                bit want;
                want = pending_found.pop_front();
                if (found !== want)
                begin
                    $error("found: expected %0b, actual %0b", want, found);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic int effective_side(input logic [btm2d_pkg::CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > SIDE)
            return SIDE;
        return int'(v);
    endfunction

    function automatic bit template_occurs();
        int n, t, i, j, k;
        bit hit;
        logic [SIDE-1:0] mask;
        n = effective_side(image_side_reg);
        t = effective_side(templ_side_reg);
        if (t > n)
            return 1'b0;
        mask = (t == SIDE) ? '1 : ((64'd1 << t) - 64'd1);
        for (i = 0; i <= n - t; i++)
        begin
            for (j = 0; j <= n - t; j++)
            begin
                hit = 1'b1;
                for (k = 0; k < t && hit; k++)
                    if (((image_px[i+k] >> j) & mask) != (templ_px[k] & mask))
                        hit = 1'b0;
                if (hit)
                    return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // entered at a rising edge; returns at the edge where the request is taken
    task automatic send_request(input logic [1:0] f, input logic [5:0] r,
                                input logic [5:0] c, input logic p);
        bit taken;
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= f;
        row      <= r;
        col      <= c;
        pixel    <= p;
        do
        begin
            @(negedge clk);
            taken = (in_stall === 1'b0);
            @(posedge clk);
        end while (!taken);
        case (f)
            btm2d_pkg::FUNC_IMAGE:
            begin
                image_px[r][c] = p;
                image_wr[r][c] = 1'b1;
            end
            btm2d_pkg::FUNC_TEMPLATE:
            begin
                templ_px[r][c] = p;
                templ_wr[r][c] = 1'b1;
            end
            btm2d_pkg::FUNC_SEARCH: pending_found.push_back(template_occurs());
            default: ;
        endcase
        if (f != FUNC_UNUSED)
            pixel_items++;
    endtask

    // load every pixel the next search will read that has never been written
    task automatic prepare_search();
        int n, t, r, c;
        n = effective_side(image_side_reg);
        t = effective_side(templ_side_reg);
        for (r = 0; r < n; r++)
            for (c = 0; c < n; c++)
                if (!image_wr[r][c])
                    send_request(btm2d_pkg::FUNC_IMAGE, 6'(r), 6'(c),
                                 1'($urandom_range(1)));
        if (t <= n)
            for (r = 0; r < t; r++)
                for (c = 0; c < t; c++)
                    if (!templ_wr[r][c])
                        send_request(btm2d_pkg::FUNC_TEMPLATE, 6'(r), 6'(c),
                                     1'($urandom_range(1)));
    endtask

    task automatic send_search();
        prepare_search();
        send_request(btm2d_pkg::FUNC_SEARCH, 6'($urandom_range(63)),
                     6'($urandom_range(63)), 1'($urandom_range(1)));
    endtask

    // drop valid, drain all results, then let the sequencer return to idle
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_found.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [btm2d_pkg::CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == btm2d_pkg::CFG_IMAGE_SIZE)
            image_side_reg = value;
        else
            templ_side_reg = value;
    endtask

    task automatic test_single_pixel();
        send_request(btm2d_pkg::FUNC_IMAGE, 6'd0, 6'd0, 1'b1);
        send_request(btm2d_pkg::FUNC_TEMPLATE, 6'd0, 6'd0, 1'b1);
        send_search();
        send_request(btm2d_pkg::FUNC_TEMPLATE, 6'd0, 6'd0, 1'b0);
        send_search();
        // stored outside the active frame, must not affect the match
        send_request(btm2d_pkg::FUNC_IMAGE, 6'd63, 6'd63, 1'b0);
        send_request(btm2d_pkg::FUNC_TEMPLATE, 6'd63, 6'd63, 1'b0);
        send_request(FUNC_UNUSED, 6'd63, 6'd63, 1'b1);
        send_search();
        send_request(btm2d_pkg::FUNC_IMAGE, 6'd0, 6'd0, 1'b0);
        send_search();
    endtask

    task automatic test_size_clamp();
        int r, c;
        wait_idle();
        write_reg(btm2d_pkg::CFG_IMAGE_SIZE, 7'd0);
        write_reg(btm2d_pkg::CFG_TEMPLATE_SIZE, 7'd0);
        send_search();
        wait_idle();
        write_reg(btm2d_pkg::CFG_IMAGE_SIZE, 7'd3);
        write_reg(btm2d_pkg::CFG_TEMPLATE_SIZE, 7'd127);
        send_search();
        wait_idle();
        write_reg(btm2d_pkg::CFG_TEMPLATE_SIZE, 7'd4);
        send_search();
        // equal sides: only offset 0,0 is tried
        wait_idle();
        write_reg(btm2d_pkg::CFG_TEMPLATE_SIZE, 7'd3);
        prepare_search();
        for (r = 0; r < 3; r++)
            for (c = 0; c < 3; c++)
                send_request(btm2d_pkg::FUNC_TEMPLATE, 6'(r), 6'(c), image_px[r][c]);
        send_search();
        send_request(btm2d_pkg::FUNC_TEMPLATE, 6'd1, 6'd2, !image_px[1][2]);
        send_search();
    endtask

    task automatic test_wide_frame();
        int r, c;
        wait_idle();
        write_reg(btm2d_pkg::CFG_IMAGE_SIZE, 7'(FRAME_SIDE));
        write_reg(btm2d_pkg::CFG_TEMPLATE_SIZE, 7'(FRAME_SIDE));
        for (r = 0; r < FRAME_SIDE; r++)
            for (c = 0; c < FRAME_SIDE; c++)
                send_request(btm2d_pkg::FUNC_IMAGE, 6'(r), 6'(c), 1'($urandom_range(1)));
        for (r = 0; r < FRAME_SIDE; r++)
            for (c = 0; c < FRAME_SIDE; c++)
                send_request(btm2d_pkg::FUNC_TEMPLATE, 6'(r), 6'(c), image_px[r][c]);
        send_search();
        send_request(btm2d_pkg::FUNC_TEMPLATE, 6'(FRAME_SIDE - 1), 6'(FRAME_SIDE - 1),
                     !image_px[FRAME_SIDE-1][FRAME_SIDE-1]);
        send_search();
        wait_idle();
        write_reg(btm2d_pkg::CFG_TEMPLATE_SIZE, 7'(FRAME_SIDE - 1));
        send_search();
        wait_idle();
        write_reg(btm2d_pkg::CFG_TEMPLATE_SIZE, 7'd1);
        send_search();
    endtask

    // one burst of writes ending in a search, usually with the template planted
    task automatic run_sequence();
        int kind, n, t, r0, c0, k, m;
        kind = $urandom_range(9);
        n = effective_side(image_side_reg);
        t = effective_side(templ_side_reg);
        prepare_search();
        repeat ($urandom_range(3))
            send_request($urandom_range(1) ? btm2d_pkg::FUNC_IMAGE : btm2d_pkg::FUNC_TEMPLATE,
                         6'($urandom_range(63)), 6'($urandom_range(63)),
                         1'($urandom_range(1)));
        if (kind < 6 && t <= n)
        begin
            if ($urandom_range(1))
                for (k = 0; k < t; k++)
                    for (m = 0; m < t; m++)
                        send_request(btm2d_pkg::FUNC_TEMPLATE, 6'(k), 6'(m),
                                     1'($urandom_range(1)));
            r0 = $urandom_range(n - t);
            c0 = $urandom_range(n - t);
            for (k = 0; k < t; k++)
                for (m = 0; m < t; m++)
                    send_request(btm2d_pkg::FUNC_IMAGE, 6'(r0 + k), 6'(c0 + m),
                                 templ_px[k][m]);
            if (kind == 5)
            begin
                // spoil the planted copy by one pixel
                k = $urandom_range(t - 1);
                m = $urandom_range(t - 1);
                send_request(btm2d_pkg::FUNC_IMAGE, 6'(r0 + k), 6'(c0 + m),
                             !templ_px[k][m]);
            end
        end
        else if (kind < 9)
        begin
            repeat ($urandom_range(1, 4))
                send_request(btm2d_pkg::FUNC_IMAGE, 6'($urandom_range(n - 1)),
                             6'($urandom_range(n - 1)), 1'($urandom_range(1)));
        end
        else
        begin
            repeat ($urandom_range(1, 3))
                send_request(FUNC_UNUSED, 6'($urandom_range(63)),
                             6'($urandom_range(63)), 1'($urandom_range(1)));
        end
        send_search();
    endtask

    task automatic test_random_traffic(input int gap, input int stall, input int quota);
        int s, n, n_val, t_val;
        int unsigned start;
        for (s = 0; s < 2; s++)
        begin
            wait_idle();
            gap_pct   = gap;
            stall_pct = stall;
            case ($urandom_range(9))
                0: n_val = 0;
                1: n_val = 1;
                default: n_val = $urandom_range(2, 8);
            endcase
            n = effective_side(7'(n_val));
            case ($urandom_range(9))
                0: t_val = 0;
                1: t_val = n + 1;
                2: t_val = $urandom_range(65, 127);
                default: t_val = $urandom_range(1, (n < 4) ? n : 4);
            endcase
            write_reg(btm2d_pkg::CFG_IMAGE_SIZE, 7'(n_val));
            write_reg(btm2d_pkg::CFG_TEMPLATE_SIZE, 7'(t_val));
            start = pixel_items;
            while (pixel_items - start < quota / 2)
                run_sequence();
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_single_pixel();
        test_size_clamp();
        test_wide_frame();
        test_random_traffic(0, 0, 175);
        test_random_traffic(76, 0, 175);
        test_random_traffic(0, 76, 175);
        test_random_traffic(24, 24, 175);
        wait_idle();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
